>>> sv/k_way_sorted_merge_core_macros.svh
// Assertion helpers for the k-way merge core checker.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef K_WAY_SORTED_MERGE_CORE_MACROS_SVH
`define K_WAY_SORTED_MERGE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KWM_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KWM_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: assertion failed");

`endif

>>> sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, types and helpers of the k-way sorted merge core.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

	localparam int LANES      = 8;
	localparam int VALUE_BITS = 32;
	localparam int LANE_W     = 3;
	localparam int CFG_W      = 4;
	localparam int IDX_W      = $clog2(LANES);
	localparam int SIZE_W     = $clog2(LANES + 1);
	localparam int ENTRY_W    = VALUE_BITS + LANE_W;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	// One heap entry: lane head value and the lane it came from
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] val;
		logic [LANE_W-1:0]            lane;
	} entry_t;

	// Kind of result to load into the output register
	typedef enum logic [1:0] {
		RES_BAD_FILL  = 2'd0,
		RES_BAD_MERGE = 2'd1,
		RES_DONE_BAD  = 2'd2,
		RES_EMIT      = 2'd3
	} res_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;    // latch the accepted request
		logic fill_ins;   // insert fill head at heap tail, start sift-up
		logic fill_skip;  // empty fill lane: count it only
		logic rep_root;   // replace root value, start sift-down
		logic pop_root;   // shrink heap, read last entry
		logic take_last;  // move last entry to root, start sift-down
		logic up_step;    // one sift-up level
		logic down_step;  // one sift-down level
		logic out_load;   // load output register
		res_t res_sel;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic merging;
		logic fill_match;
		logic fill_last;
		logic empty;
		logic last_one;
		logic root_match;
		logic in_ex;
		logic up_stop;
		logic down_stop;
	} sts_t;

	// Heap order: smaller value first, lower lane on ties
	function automatic logic precedes(entry_t a, entry_t b);
		logic lt;
		lt = ($signed(a.val) < $signed(b.val)) ||
			(($signed(a.val) == $signed(b.val)) && (a.lane < b.lane));
		return lt;
	endfunction

endpackage

`default_nettype wire

>>> sv/kwm_in_if.sv
// ----------------------------------------------------------------------------
// kwm_in_if
// Request channel of the merge core: lane head or exhaust mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwm_in_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           lane;
	logic signed [31:0]   value;
	logic                 exhausted;

	modport source (output valid, output lane, output value, output exhausted, input ready);
	modport sink   (input valid, input lane, input value, input exhausted, output ready);
endinterface

`default_nettype wire

>>> sv/kwm_out_if.sv
// ----------------------------------------------------------------------------
// kwm_out_if
// Result channel of the merge core: merged element, done and error flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwm_out_if;
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   smallest;
	logic [2:0]           source_lane;
	logic                 done_res;
	logic                 bad_lane;

	modport source (output valid, output smallest, output source_lane, output done_res,
		output bad_lane, input ready);
	modport sink   (input valid, input smallest, input source_lane, input done_res,
		input bad_lane, output ready);
endinterface

`default_nettype wire

>>> sv/k_way_sorted_merge_core.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// Merges up to eight ascending lanes into one ascending stream (min-heap).
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one request per lane head: during fill, lanes 0, 1, 2 ...
//    in order (value or exhausted); while merging, the next element of the
//    lane last reported on out_ch, or its exhausted mark.
//  - out_ch returns the current minimum and its lane, done_res once every
//    lane is exhausted, or bad_lane when the request named the wrong lane
//    (that request is dropped).
//  - cfg_we / cfg_wdata set the number of lanes in use; write it while idle.
//  - One request at a time: accept, decode, then the heap sift at
//    one level per cycle (up to log2(LANES) levels, three for eight lanes)
//    through the two-port heap RAM, plus a pop read when a lane is
//    exhausted and the output register load.
//  - A finished result waits in the output register while the next request
//    is accepted; if the receiver stalls, the following result holds in the
//    core until the register frees up.
//  - Reset clears heap size, fill count and the merge flag and sets eight
//    lanes in use; heap contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_sorted_merge_core import kwm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	kwm_in_if.sink                in_ch,
	kwm_out_if.source             out_ch,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kwm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_lane      (in_ch.lane),
		.in_value     (in_ch.value),
		.in_exhausted (in_ch.exhausted),
		.cmd          (cmd),
		.sts          (sts),
		.smallest     (out_ch.smallest),
		.source_lane  (out_ch.source_lane),
		.done_res     (out_ch.done_res),
		.bad_lane     (out_ch.bad_lane)
	);

endmodule

`default_nettype wire

>>> sv/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

>>> sv/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath
// Heap storage, sift compare unit, counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_datapath import kwm_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_W-1:0]             cfg_wdata,
	input  wire logic [LANE_W-1:0]            in_lane,
	input  wire logic signed [VALUE_BITS-1:0] in_value,
	input  wire logic                         in_exhausted,
	input  wire cmd_t                         cmd,
	output sts_t                              sts,
	output logic signed [VALUE_BITS-1:0]      smallest,
	output logic [LANE_W-1:0]                 source_lane,
	output logic                              done_res,
	output logic                              bad_lane
);

	logic [CFG_W-1:0]             lanes_q;
	logic [LANE_W-1:0]            lane_in_q;
	logic signed [VALUE_BITS-1:0] val_in_q;
	logic                         ex_in_q;
	logic [SIZE_W-1:0]            size_q;
	logic [SIZE_W-1:0]            fill_q;
	logic                         merging_q;
	entry_t                       root_q;
	entry_t                       cur_q;
	logic [IDX_W-1:0]             pos_q;

	logic [ENTRY_W-1:0] rdata_a, rdata_b;
	entry_t             rd_a, rd_b;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic [IDX_W-1:0]   raddr_a, raddr_b;
	logic [IDX_W-1:0]   pos_nx;

	int unsigned        lanes_eff;
	int unsigned        left_w, right_w;
	logic               take_l, take_r;
	entry_t             best_l;
	logic               up_stop, down_stop;
	logic [IDX_W-1:0]   parent_pos, m_pos;

	assign rd_a = entry_t'(rdata_a);
	assign rd_b = entry_t'(rdata_b);

	kwm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (LANES)
	) u_heap (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Clamp lane count to 1..LANES
	always_comb begin
		if (lanes_q == '0) begin
			lanes_eff = 1;
		end else if (int'(lanes_q) > LANES) begin
			lanes_eff = LANES;
		end else begin
			lanes_eff = int'(lanes_q);
		end
	end

	// Sift compare unit
	assign parent_pos = IDX_W'((int'(pos_q) - 1) >> 1);
	assign up_stop    = (pos_q == '0) || !precedes(cur_q, rd_a);

	assign left_w  = 2 * int'(pos_q) + 1;
	assign right_w = 2 * int'(pos_q) + 2;
	assign take_l  = (left_w < int'(size_q)) && precedes(rd_a, cur_q);
	assign best_l  = take_l ? rd_a : cur_q;
	assign take_r  = (right_w < int'(size_q)) && precedes(rd_b, best_l);
	assign down_stop = !take_l && !take_r;

	always_comb begin
		if (take_r) begin
			m_pos = IDX_W'(right_w);
		end else if (take_l) begin
			m_pos = IDX_W'(left_w);
		end else begin
			m_pos = pos_q;
		end
	end

	// Next position of the moving entry
	always_comb begin
		if (cmd.fill_ins) begin
			pos_nx = IDX_W'(size_q);
		end else if (cmd.up_step) begin
			pos_nx = up_stop ? pos_q : parent_pos;
		end else if (cmd.down_step) begin
			pos_nx = m_pos;
		end else if (cmd.rep_root || cmd.take_last) begin
			pos_nx = '0;
		end else begin
			pos_nx = pos_q;
		end
	end

	// Read addresses for the next compare; out-of-heap reads are ignored
	always_comb begin
		raddr_b = IDX_W'(2 * int'(pos_nx) + 2);
		if (cmd.pop_root) begin
			raddr_a = IDX_W'(int'(size_q) - 1);
		end else if (cmd.fill_ins || cmd.up_step) begin
			raddr_a = IDX_W'((int'(pos_nx) - 1) >> 1);
		end else begin
			raddr_a = IDX_W'(2 * int'(pos_nx) + 1);
		end
	end

	// Heap write: settle the moving entry or pull a neighbor into its slot
	always_comb begin
		we    = cmd.up_step || cmd.down_step;
		waddr = pos_q;
		if (cmd.up_step) begin
			wdata = up_stop ? cur_q : rd_a;
		end else if (take_r) begin
			wdata = rd_b;
		end else if (take_l) begin
			wdata = rd_a;
		end else begin
			wdata = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q   <= CFG_RESET;
			size_q    <= '0;
			fill_q    <= '0;
			merging_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lanes_q <= cfg_wdata;
			end
			if (cmd.fill_ins) begin
				size_q <= size_q + SIZE_W'(1);
			end else if (cmd.pop_root) begin
				size_q <= size_q - SIZE_W'(1);
			end
			if (cmd.fill_ins || cmd.fill_skip) begin
				fill_q <= fill_q + SIZE_W'(1);
				if (sts.fill_last) begin
					merging_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lane_in_q <= in_lane;
			val_in_q  <= in_value;
			ex_in_q   <= in_exhausted;
		end
		pos_q <= pos_nx;
		if (cmd.fill_ins) begin
			cur_q <= '{val: val_in_q, lane: lane_in_q};
		end else if (cmd.rep_root) begin
			cur_q <= '{val: val_in_q, lane: root_q.lane};
		end else if (cmd.take_last) begin
			cur_q <= rd_a;
		end
		// Mirror heap slot zero
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.res_sel)
				RES_BAD_FILL: begin
					smallest    <= '0;
					source_lane <= LANE_W'(fill_q);
					done_res    <= 1'b0;
					bad_lane    <= 1'b1;
				end
				RES_BAD_MERGE: begin
					smallest    <= '0;
					source_lane <= root_q.lane;
					done_res    <= 1'b0;
					bad_lane    <= 1'b1;
				end
				RES_DONE_BAD: begin
					smallest    <= '0;
					source_lane <= '0;
					done_res    <= 1'b1;
					bad_lane    <= 1'b1;
				end
				RES_EMIT: begin
					smallest    <= (size_q == '0) ? '0 : root_q.val;
					source_lane <= (size_q == '0) ? '0 : root_q.lane;
					done_res    <= (size_q == '0);
					bad_lane    <= 1'b0;
				end
				default: begin
					smallest    <= '0;
					source_lane <= '0;
					done_res    <= 1'b0;
					bad_lane    <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		sts.merging    = merging_q;
		sts.fill_match = (int'(fill_q) == int'(lane_in_q));
		sts.fill_last  = (int'(fill_q) + 1 >= lanes_eff);
		sts.empty      = (size_q == '0);
		sts.last_one   = (size_q == SIZE_W'(1));
		sts.root_match = (root_q.lane == lane_in_q);
		sts.in_ex      = ex_in_q;
		sts.up_stop    = up_stop;
		sts.down_stop  = down_stop;
	end

endmodule

`default_nettype wire

>>> sv/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer of the merge core: decode request, run sift, deliver result.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_ctrl import kwm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_LAST   = 6'b000100,
		ST_UP     = 6'b001000,
		ST_DOWN   = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_nx;
	res_t   res_q, res_nx;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		res_nx   = res_q;
		cmd      = '0;
		cmd.res_sel = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!sts.merging) begin
					if (!sts.fill_match) begin
						res_nx   = RES_BAD_FILL;
						state_nx = ST_RESULT;
					end else if (!sts.in_ex) begin
						cmd.fill_ins = 1'b1;
						state_nx     = ST_UP;
					end else begin
						cmd.fill_skip = 1'b1;
						res_nx        = RES_EMIT;
						state_nx      = sts.fill_last ? ST_RESULT : ST_IDLE;
					end
				end else if (sts.empty) begin
					res_nx   = RES_DONE_BAD;
					state_nx = ST_RESULT;
				end else if (!sts.root_match) begin
					res_nx   = RES_BAD_MERGE;
					state_nx = ST_RESULT;
				end else if (sts.in_ex) begin
					cmd.pop_root = 1'b1;
					res_nx       = RES_EMIT;
					state_nx     = sts.last_one ? ST_RESULT : ST_LAST;
				end else begin
					cmd.rep_root = 1'b1;
					state_nx     = ST_DOWN;
				end
			end
			ST_LAST: begin
				cmd.take_last = 1'b1;
				state_nx      = ST_DOWN;
			end
			ST_UP: begin
				cmd.up_step = 1'b1;
				if (sts.up_stop) begin
					res_nx   = RES_EMIT;
					state_nx = sts.merging ? ST_RESULT : ST_IDLE;
				end
			end
			ST_DOWN: begin
				cmd.down_step = 1'b1;
				if (sts.down_stop) begin
					res_nx   = RES_EMIT;
					state_nx = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= RES_EMIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			res_q   <= res_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the merge core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_way_sorted_merge_core_macros.svh"

module kwm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] smallest,
	input wire logic [2:0]  source_lane,
	input wire logic        done_res,
	input wire logic        bad_lane
);

	// A stalled result keeps its payload
	`KWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(smallest) && $stable(source_lane) && $stable(done_res) && $stable(bad_lane))

	// One request at a time: busy right after an accept
	`KWM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// Done carries no element and no lane
	`KWM_ASSERT_NOW(a_done_clean, out_valid && done_res, smallest == '0 && source_lane == '0)

endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.smallest    (out_ch.smallest),
	.source_lane (out_ch.source_lane),
	.done_res    (out_ch.done_res),
	.bad_lane    (out_ch.bad_lane)
);

`default_nettype wire

>>> dv/k_way_sorted_merge_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core_tb
// Fills the lane heads, then feeds follow-up elements of the lane at the heap
// root with random stalls on both channels. A scoreboard class keeps its own
// min-heap of lane heads and checks every result in order.
// ----------------------------------------------------------------------------

module k_way_sorted_merge_core_tb import kwm_pkg::*; ();

	typedef logic signed [VALUE_BITS-1:0] elem_t;
	typedef logic [LANE_W-1:0]            lane_t;

	typedef struct {
		elem_t smallest;
		lane_t source_lane;
		bit    done_res;
		bit    bad_lane;
	} merge_res_t;

	localparam int    SETTLE_CYCLES = 20;
	localparam int    CYCLE_LIMIT   = 400000;
	localparam int    RANDOM_ITEMS  = 500;
	localparam elem_t ELEM_MIN      = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam elem_t ELEM_MAX      = {1'b0, {(VALUE_BITS-1){1'b1}}};

	class merge_scoreboard;
		elem_t            head_val[LANES];
		lane_t            head_lane[LANES];
		int               heap_cnt;
		int               fill_pos;
		bit               merging;
		logic [CFG_W-1:0] lanes_reg;
		merge_res_t       expected_mins[$];
		int               requests, results, emits, dones, refusals, mismatches;

		function new();
			foreach (head_val[k]) begin
				head_val[k]  = '0;
				head_lane[k] = '0;
			end
			heap_cnt   = 0;
			fill_pos   = 0;
			merging    = 1'b0;
			lanes_reg  = CFG_RESET;
			requests   = 0;
			results    = 0;
			emits      = 0;
			dones      = 0;
			refusals   = 0;
			mismatches = 0;
		endfunction

		function void set_lanes(logic [CFG_W-1:0] v);
			lanes_reg = v;
		endfunction

		function int pending();
			return expected_mins.size();
		endfunction

		function int heap_count();
			return heap_cnt;
		endfunction

		function lane_t root_lane();
			return head_lane[0];
		endfunction

		// True when a request for this lane would change the heads
		function bit applies_to(lane_t lane);
			if (!merging)
				return int'(lane) == fill_pos;
			return heap_cnt > 0 && lane == head_lane[0];
		endfunction

		function int lanes_active();
			int n;
			n = int'(lanes_reg);
			if (n < 1)
				n = 1;
			if (n > LANES)
				n = LANES;
			return n;
		endfunction

		// Smaller value wins, lower lane on ties
		function bit ahead(int a, int b);
			if (head_val[a] != head_val[b])
				return head_val[a] < head_val[b];
			return head_lane[a] < head_lane[b];
		endfunction

		function void swap_heads(int a, int b);
			elem_t v;
			lane_t l;
			v = head_val[a];
			l = head_lane[a];
			head_val[a]  = head_val[b];
			head_lane[a] = head_lane[b];
			head_val[b]  = v;
			head_lane[b] = l;
		endfunction

		function void sift_up(int i);
			int p;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!ahead(i, p))
					break;
				swap_heads(i, p);
				i = p;
			end
		endfunction

		function void sift_down(int i);
			int l, r, m;
			forever begin
				l = 2 * i + 1;
				r = l + 1;
				m = i;
				if (l < heap_cnt && ahead(l, m))
					m = l;
				if (r < heap_cnt && ahead(r, m))
					m = r;
				if (m == i)
					break;
				swap_heads(i, m);
				i = m;
			end
		endfunction

		function void push_res(elem_t v, lane_t l, bit d, bit b);
			merge_res_t e;
			e.smallest    = v;
			e.source_lane = l;
			e.done_res    = d;
			e.bad_lane    = b;
			expected_mins.push_back(e);
		endfunction

		function void push_min();
			if (heap_cnt == 0)
				push_res('0, '0, 1'b1, 1'b0);
			else
				push_res(head_val[0], head_lane[0], 1'b0, 1'b0);
		endfunction

		function void note_request(lane_t lane, elem_t value, bit ex);
			requests++;
			if (!merging) begin
				if (int'(lane) != fill_pos) begin
					push_res('0, lane_t'(fill_pos), 1'b0, 1'b1);
					return;
				end
				if (!ex && heap_cnt < LANES) begin
					head_val[heap_cnt]  = value;
					head_lane[heap_cnt] = lane;
					heap_cnt++;
					sift_up(heap_cnt - 1);
				end
				fill_pos++;
				if (fill_pos >= lanes_active()) begin
					merging = 1'b1;
					push_min();
				end
				return;
			end
			if (heap_cnt == 0) begin
				push_res('0, '0, 1'b1, 1'b1);
				return;
			end
			if (lane != head_lane[0]) begin
				push_res('0, head_lane[0], 1'b0, 1'b1);
				return;
			end
			// exhausted lane: move the tail to the root; else replace the root value
			if (ex) begin
				heap_cnt--;
				head_val[0]  = head_val[heap_cnt];
				head_lane[0] = head_lane[heap_cnt];
			end else begin
				head_val[0] = value;
			end
			sift_down(0);
			push_min();
		endfunction

		function void check_result(elem_t smallest, lane_t src, bit done_res, bit bad_lane);
			merge_res_t e;
			results++;
			if (expected_mins.size() == 0) begin
				$error("result with no request outstanding: smallest %0d lane %0d done %0b bad %0b",
					smallest, src, done_res, bad_lane);
				mismatches++;
				return;
			end
			e = expected_mins.pop_front();
			if (e.bad_lane)
				refusals++;
			else if (e.done_res)
				dones++;
			else
				emits++;
			if (smallest !== e.smallest) begin
				$error("smallest: expected %0d, got %0d", e.smallest, smallest);
				mismatches++;
			end
			if (src !== e.source_lane) begin
				$error("source_lane: expected %0d, got %0d", e.source_lane, src);
				mismatches++;
			end
			if (done_res !== e.done_res) begin
				$error("done_res: expected %0b, got %0b", e.done_res, done_res);
				mismatches++;
			end
			if (bad_lane !== e.bad_lane) begin
				$error("bad_lane: expected %0b, got %0b", e.bad_lane, bad_lane);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	kwm_in_if  in_ch();
	kwm_out_if out_ch();

	k_way_sorted_merge_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	merge_scoreboard sb = new();
	elem_t           last_sent[LANES];
	bit              burst;
	int              cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Next element of an ascending lane, saturating at the top value
	function automatic elem_t next_up(elem_t last);
		longint nxt;
		if ($urandom_range(0, 9) == 0)
			nxt = longint'(last);
		else
			nxt = longint'(last) + longint'($urandom_range(1, 1 << 26));
		if (nxt > longint'(ELEM_MAX))
			nxt = longint'(ELEM_MAX);
		return elem_t'(nxt);
	endfunction

	task automatic send_request(lane_t lane, elem_t value, bit ex);
		int gap;
		in_ch.valid     <= 1'b1;
		in_ch.lane      <= lane;
		in_ch.value     <= value;
		in_ch.exhausted <= ex;
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (!ex && sb.applies_to(lane))
			last_sent[lane] = value;
		sb.note_request(lane, value, ex);
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every result is back and the core has settled
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_lanes(logic [CFG_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_lanes(v);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.smallest, out_ch.source_lane, out_ch.done_res,
				out_ch.bad_lane);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: ready runs of random length, mostly short stalls
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			out_ch.ready <= 1'b1;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
			repeat (n) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		int    r;
		lane_t ln;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.lane      = '0;
		in_ch.value     = '0;
		in_ch.exhausted = 1'b0;
		burst           = 1'b0;
		foreach (last_sent[k])
			last_sent[k] = ELEM_MIN;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill phase: wrong lane, extreme heads, an empty lane, ties
		write_lanes(4'd15);
		send_request(3'd3, 123, 1'b0);
		send_request(3'd0, ELEM_MIN, 1'b0);
		send_request(3'd1, ELEM_MAX, 1'b0);
		send_request(3'd2, 32'hDEAD_BEEF, 1'b1);
		write_lanes(4'd9);
		send_request(3'd3, 0, 1'b0);
		send_request(3'd4, -1, 1'b0);
		send_request(3'd5, ELEM_MIN, 1'b0);
		// fill count is already past the new lane count: the next head ends the fill
		write_lanes(4'd0);
		send_request(3'd6, 7, 1'b0);

		// Merge phase: wrong lane, tie on replace, exhaust, jump to the top value
		send_request(lane_t'(sb.root_lane() + 1), ELEM_MAX, 1'b1);
		send_request(sb.root_lane(), ELEM_MIN, 1'b0);
		send_request(sb.root_lane(), 32'h5555_AAAA, 1'b1);
		send_request(sb.root_lane(), ELEM_MAX, 1'b0);
		write_lanes(4'd1);
		write_lanes(4'd8);
		send_request(sb.root_lane(), -5, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				write_lanes(4'($urandom_range(0, 15)));
			r  = $urandom_range(0, 99);
			ln = sb.root_lane();
			if (r < 8)
				send_request(lane_t'(ln + $urandom_range(1, 7)), elem_t'($urandom),
					1'($urandom_range(0, 1)));
			else if (r < 9 && sb.heap_count() > 2)
				send_request(ln, elem_t'($urandom), 1'b1);
			else if (r < 19)
				send_request(ln, elem_t'($urandom), 1'b0);
			else
				send_request(ln, next_up(last_sent[ln]), 1'b0);
		end

		// Exhaust the remaining lanes, then poke the finished core
		while (sb.heap_count() > 0)
			send_request(sb.root_lane(), elem_t'($urandom), 1'b1);
		repeat (3)
			send_request(lane_t'($urandom_range(0, 7)), elem_t'($urandom),
				1'($urandom_range(0, 1)));
		in_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Merged %0d elements from %0d requests; %0d requests refused, %0d done reports.",
			sb.emits, sb.requests, sb.refusals, sb.dones);
		$display("Lane counts 15, 9, 0, 1 and 8 written; %0d results checked in %0d cycles.",
			sb.results, cycles);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
